>>> hdl/address_cache_fifo_replace_assert.svh
// Assertion macros used by the address cache top level.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ADDRESS_CACHE_FIFO_REPLACE_ASSERT_SVH
`define ADDRESS_CACHE_FIFO_REPLACE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/acfr_pkg.sv
// Package for the address cache: field widths, defaults, mode codes and
// the search token that travels along the cell row. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acfr_pkg;

  localparam int unsigned KEY_W     = 16;
  localparam int unsigned HW_W      = 48;
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned DEPTH_DEF = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_INSERT = 1'b1
  } mode_e;

  // Search token handed from one cell to the next.
  typedef struct packed {
    logic            valid;
    logic [KEY_W-1:0] key;
    logic            hit;
    logic [HW_W-1:0]  addr;
  } token_t;

endpackage

`default_nettype wire

>>> hdl/acfr_req_if.sv
// Request channel of the address cache: valid/ready plus the item fields.
// Depends on acfr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface acfr_req_if;
  import acfr_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [KEY_W-1:0]  key_address;
  logic [HW_W-1:0]   hw_address;

  modport source (output valid, output mode, output key_address, output hw_address,
                  input ready);
  modport sink   (input valid, input mode, input key_address, input hw_address,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/acfr_rsp_if.sv
// Response channel of the address cache: valid/ready plus the result fields.
// Depends on acfr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface acfr_rsp_if;
  import acfr_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [HW_W-1:0]  found_address;

  modport source (output valid, output hit, output found_address, input ready);
  modport sink   (input valid, input hit, input found_address, output ready);
endinterface

`default_nettype wire

>>> hdl/acfr_cell.sv
// One entry of the address cache: stores a key and hardware address and
// checks the passing search token against them. Depends on acfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acfr_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [acfr_pkg::KEY_W-1:0]   wr_key_i,
  input  logic [acfr_pkg::HW_W-1:0]    wr_addr_i,
  input  logic                         in_range_i,
  input  acfr_pkg::token_t             tok_i,
  output acfr_pkg::token_t             tok_o
);
  import acfr_pkg::*;

  logic [KEY_W-1:0] key_q;
  logic [HW_W-1:0]  addr_q;
  token_t           tok_d, tok_q;

  // Entry storage, written by an insert that targets this cell.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_q  <= wr_key_i;
      addr_q <= wr_addr_i;
    end
  end

  // The first valid match claims the token; later cells pass it unchanged.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && in_range_i && !tok_i.hit && (key_q == tok_i.key)) begin
      tok_d.hit  = 1'b1;
      tok_d.addr = addr_q;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

>>> hdl/address_cache_fifo_replace.sv
// Address cache top level with first-in first-out replacement.
// Channels: req_i carries items (mode, key_address, hw_address) in, rsp_o
// carries one result (hit, found_address) out per item. Both are valid/ready;
// an item moves on an edge where valid and ready are both high.
// Insert: the entry is written at the write pointer and the result (hit 0,
// address 0) is in the output register in the cycle after acceptance, so inserts
// can follow each other every cycle while the receiver keeps up.
// Lookup: a search token enters the row of DEPTH cells and moves one cell per
// cycle; the lowest-index valid match claims it. The result is registered in the
// output register when the token leaves the last cell. No other item is taken
// while a lookup runs; the next can be taken in the cycle its result is taken.
// cfg_we_i/cfg_wdata_i write size_in_use; write it only while the block is idle.
// A size of zero acts as one and a size above DEPTH acts as DEPTH.
// Reset sets size_in_use to 16 and clears the write pointer and valid count;
// entry contents are not cleared, so entries never written can still be searched.
// When the receiver stalls, the result holds in the output register and no
// new item is accepted until it is taken (or in the cycle it is taken).
// Depends on acfr_pkg, acfr_req_if, acfr_rsp_if, acfr_cell and the assert header.
`timescale 1ns / 1ps
`default_nettype none

`include "address_cache_fifo_replace_assert.svh"

module address_cache_fifo_replace #(
  parameter int unsigned DEPTH = acfr_pkg::DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  acfr_req_if.sink                      req_i,
  acfr_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [acfr_pkg::SIZE_W-1:0]   cfg_wdata_i
);
  import acfr_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  wp_q, wp_d, vc_q, vc_d;
  logic [CNT_W-1:0]  eff_size, wp_eff;
  logic [CMP_W-1:0]  size_ext;
  logic              busy_q, busy_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_hit_q, rsp_hit_d;
  logic [HW_W-1:0]   rsp_addr_q, rsp_addr_d;
  logic              accept, do_insert, do_lookup;
  token_t            tok [DEPTH+1];
  logic [DEPTH-1:0]  tok_valid_vec;

  // Handshake decode.
  assign req_i.ready = !busy_q && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign do_insert   = accept && (req_i.mode == MODE_INSERT);
  assign do_lookup   = accept && (req_i.mode == MODE_LOOKUP);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Effective size: zero acts as one, anything above DEPTH acts as DEPTH.
  always_comb begin
    size_ext = CMP_W'(size_q);
    if (size_q == '0) begin
      eff_size = CNT_W'(1);
    end else if (size_ext > CMP_W'(DEPTH)) begin
      eff_size = CNT_W'(DEPTH);
    end else begin
      eff_size = size_ext[CNT_W-1:0];
    end
  end

  // Write pointer wraps before the write, valid count saturates at the size.
  always_comb begin
    wp_eff = (wp_q >= eff_size) ? '0 : wp_q;
    wp_d   = wp_q;
    vc_d   = vc_q;
    if (do_insert) begin
      wp_d = wp_eff + CNT_W'(1);
      if (vc_q < eff_size) begin
        vc_d = vc_q + CNT_W'(1);
      end
    end
  end

  // Launch token for a lookup.
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = do_lookup;
    tok[0].key   = req_i.key_address;
  end

  // Row of cells.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    acfr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (do_insert && (wp_eff == CNT_W'(i))),
      .wr_key_i   (req_i.key_address),
      .wr_addr_i  (req_i.hw_address),
      .in_range_i (vc_q > CNT_W'(i)),
      .tok_i      (tok[i]),
      .tok_o      (tok[i+1])
    );
    assign tok_valid_vec[i] = tok[i+1].valid;
  end

  // Output register and busy flag.
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_hit_d   = rsp_hit_q;
    rsp_addr_d  = rsp_addr_q;
    busy_d      = busy_q;
    if (do_insert) begin
      rsp_valid_d = 1'b1;
      rsp_hit_d   = 1'b0;
      rsp_addr_d  = '0;
    end else if (tok[DEPTH].valid) begin
      rsp_valid_d = 1'b1;
      rsp_hit_d   = tok[DEPTH].hit;
      rsp_addr_d  = tok[DEPTH].hit ? tok[DEPTH].addr : '0;
      busy_d      = 1'b0;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (do_lookup) begin
      busy_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      vc_q        <= '0;
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      wp_q        <= wp_d;
      vc_q        <= vc_d;
      busy_q      <= busy_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    rsp_hit_q  <= rsp_hit_d;
    rsp_addr_q <= rsp_addr_d;
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.hit           = rsp_hit_q;
  assign rsp_o.found_address = rsp_addr_q;

  // Checks on the block's own control.
  `ACFR_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_valid_vec), "more than one search token")
  `ACFR_ASSERT_NOW(a_busy_blocks, busy_q, !req_i.ready, "item taken while a lookup runs")
  `ACFR_ASSERT_NOW(a_bounds, 1'b1, (wp_q <= CNT_W'(DEPTH)) && (vc_q <= CNT_W'(DEPTH)), "pointer or count out of range")
  `ACFR_ASSERT_NEXT(a_insert_rsp, do_insert, rsp_valid_q && !rsp_hit_q, "insert result missing")
  `ACFR_ASSERT_NOW(a_miss_zero, rsp_valid_q && !rsp_hit_q, rsp_addr_q == '0, "miss with nonzero address")

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the address cache with first-in first-out replacement.
// Drives items through acfr_req_if and checks each result on acfr_rsp_if against
// a shadow copy of the cache. Depends on acfr_pkg, both interfaces and the RTL top.
`timescale 1ns / 1ps

module testbench;
  import acfr_pkg::*;

  localparam int unsigned CACHE_DEPTH = DEPTH_DEF;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned STALL_LIMIT = 2000;

  // One expected result: hit flag and resolved hardware address.
  typedef struct packed {
    logic            hit;
    logic [HW_W-1:0] addr;
  } cache_reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SIZE_W-1:0]   cfg_wdata_i;

  acfr_req_if req ();
  acfr_rsp_if rsp ();

  address_cache_fifo_replace #(
    .DEPTH (CACHE_DEPTH)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the cache contents, pointer, fill level and size register.
  logic [KEY_W-1:0]  shadow_keys [CACHE_DEPTH];
  logic [HW_W-1:0]   shadow_hw [CACHE_DEPTH];
  bit                shadow_written [CACHE_DEPTH];
  int unsigned       shadow_wptr = 0;
  int unsigned       shadow_count = 0;
  logic [SIZE_W-1:0] shadow_size = SIZE_RESET;

  cache_reply_t      expected_replies [$];
  logic [KEY_W-1:0]  key_pool [8];

  int unsigned errors = 0;
  int unsigned sink_wait = 0;
  int unsigned sink_hold = 0;
  int unsigned stall_cycles = 0;
  bit          hold_request = 1'b0;
  bit          pace_free = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Size in effect: zero behaves as one and anything above the depth as the depth.
  function automatic int unsigned effective_size();
    int unsigned s;
    s = shadow_size;
    if (s == 0) s = 1;
    if (s > CACHE_DEPTH) s = CACHE_DEPTH;
    return s;
  endfunction

  // Apply one item to the shadow cache and return the result it should produce.
  function automatic cache_reply_t apply_request(input mode_e op,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [HW_W-1:0] hw);
    cache_reply_t rp;
    int unsigned  span;
    int unsigned  limit;
    rp = '0;
    span = effective_size();
    if (op == MODE_INSERT) begin
      if (shadow_wptr >= span) shadow_wptr = 0;
      shadow_keys[shadow_wptr] = key;
      shadow_hw[shadow_wptr] = hw;
      shadow_written[shadow_wptr] = 1'b1;
      shadow_wptr++;
      if (shadow_count < span) shadow_count++;
    end else begin
      limit = (shadow_count > CACHE_DEPTH) ? CACHE_DEPTH : shadow_count;
      for (int i = 0; i < limit; i++) begin
        if (shadow_keys[i] == key) begin
          rp.hit = 1'b1;
          rp.addr = shadow_hw[i];
          break;
        end
      end
    end
    return rp;
  endfunction

  // A lookup is only legal when every entry below the fill level has been written.
  function automatic bit lookup_safe();
    for (int i = 0; i < shadow_count && i < CACHE_DEPTH; i++) begin
      if (!shadow_written[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned idle_draw();
    return pace_free ? 0 : $urandom_range(0, 6);
  endfunction

  // Mostly keys from a small pool so that lookups hit, plus the extremes and noise.
  function automatic logic [KEY_W-1:0] draw_key();
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return KEY_W'($urandom);
      end
      default: begin
        return key_pool[$urandom_range(0, 7)];
      end
    endcase
  endfunction

  // Offer one item after a random gap and record its expected result on acceptance.
  task automatic send_item(input mode_e op, input logic [KEY_W-1:0] key,
                           input logic [HW_W-1:0] hw);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.mode        <= op;
    req.key_address <= key;
    req.hw_address  <= hw;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    expected_replies.push_back(apply_request(op, key, hw));
  endtask

  // Stop offering items, wait for every pending result, then let the block settle.
  task automatic settle_idle();
    req.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (CACHE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_size = value;
  endtask

  // One setting of the size register followed by a random mix of inserts and lookups.
  task automatic run_random_phase(input logic [SIZE_W-1:0] size_value,
                                  input int unsigned count);
    logic [63:0] bits;
    mode_e       op;
    settle_idle();
    write_size(size_value);
    pace_free = ($urandom_range(0, 3) == 0);
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) pace_free = !pace_free;
      op = (!lookup_safe() || $urandom_range(0, 9) < 4) ? MODE_INSERT : MODE_LOOKUP;
      bits = {$urandom, $urandom};
      send_item(op, draw_key(), bits[HW_W-1:0]);
    end
  endtask

  // Empty table, the key and address extremes, duplicate keys and misses.
  task automatic test_basic_lookups();
    send_item(MODE_LOOKUP, 16'h0000, 48'h0000_0000_0000);
    send_item(MODE_LOOKUP, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_item(MODE_INSERT, 16'h0000, 48'h0000_0000_0000);
    send_item(MODE_INSERT, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_item(MODE_INSERT, 16'h1234, 48'h0A0B_0C0D_0E0F);
    send_item(MODE_INSERT, 16'h1234, 48'h5555_5555_5555);
    send_item(MODE_INSERT, 16'hABCD, 48'hAAAA_AAAA_AAAA);
    send_item(MODE_LOOKUP, 16'h0000, 48'hFFFF_FFFF_FFFF);
    send_item(MODE_LOOKUP, 16'hFFFF, 48'h0000_0000_0000);
    send_item(MODE_LOOKUP, 16'h1234, 48'h0000_0000_0000);
    send_item(MODE_LOOKUP, 16'hABCD, 48'h1234_5678_9ABC);
    send_item(MODE_LOOKUP, 16'h4321, 48'h0000_0000_0000);
  endtask

  // The receiver holds off while items keep coming, then the sender drains and resumes.
  task automatic test_backpressure();
    logic [63:0] bits;
    settle_idle();
    pace_free = 1'b1;
    hold_request = 1'b1;
    repeat (20) begin
      bits = {$urandom, $urandom};
      send_item((lookup_safe() && $urandom_range(0, 1)) ? MODE_LOOKUP : MODE_INSERT,
                draw_key(), bits[HW_W-1:0]);
    end
    settle_idle();
    pace_free = 1'b0;
    repeat (20) begin
      bits = {$urandom, $urandom};
      send_item((lookup_safe() && $urandom_range(0, 1)) ? MODE_LOOKUP : MODE_INSERT,
                draw_key(), bits[HW_W-1:0]);
    end
  endtask

  // Walk the size register through its extremes, including lowering below the fill level.
  task automatic test_size_sweep();
    run_random_phase(5'd16, 145);
    run_random_phase(5'd1, 145);
    run_random_phase(5'd0, 145);
    run_random_phase(5'd31, 145);
    run_random_phase(5'd3, 145);
    run_random_phase(5'd17, 145);
    run_random_phase(5'd8, 145);
    run_random_phase(5'd2, 145);
    run_random_phase(5'd16, 145);
    run_random_phase(5'd5, 145);
    run_random_phase(5'd12, 145);
  endtask

  // Result checker and receiver pacing, including the long hold-off.
  always @(posedge clk_i) begin : reply_sink
    cache_reply_t want;
    if (rst_ni === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: hit %0b address %h",
                 $time, rsp.hit, rsp.found_address);
      end else begin
        want = expected_replies.pop_front();
        if (rsp.hit !== want.hit) begin
          errors++;
          $display("%0t: hit mismatch: expected %0b, actual %0b",
                   $time, want.hit, rsp.hit);
        end
        if (rsp.found_address !== want.addr) begin
          errors++;
          $display("%0t: found_address mismatch: expected %h, actual %h",
                   $time, want.addr, rsp.found_address);
        end
      end
      sink_wait = idle_draw();
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    if (hold_request) begin
      sink_hold = LONG_HOLD;
      hold_request = 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
    end
    rsp.ready <= (sink_wait == 0 && sink_hold == 0);
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    req.valid       = 1'b0;
    req.mode        = MODE_LOOKUP;
    req.key_address = '0;
    req.hw_address  = '0;
    rsp.ready       = 1'b0;
    foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_lookups();
    test_backpressure();
    test_size_sweep();
    settle_idle();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
